### rtl/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmcw_pkg;

    localparam int ATTR_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int START_ROW = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ATTR = 1'd1;

    localparam logic [7:0]  CHAR_NUL        = 8'h00;
    localparam logic [7:0]  CHAR_BS         = 8'h08;
    localparam logic [7:0]  CHAR_NL         = 8'h0A;
    localparam logic [15:0] CELL_BLANK      = 16'h0700;
    localparam logic [7:0]  NORMAL_ATTR_RST = 8'h07;
    localparam logic [7:0]  CURSOR_ATTR_RST = 8'h70;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
    } t_out_item;

    // controller -> datapath strobes
    typedef struct packed {
        logic latch;      // take the input item
        logic clr_wr;     // reset sweep: blank cell at pointer
        logic look;       // read cursor cell or addressed cell
        logic load_read;  // load read result into output register
        logic edit;       // rewrite old cursor cell, move cursor
        logic sc_prime;   // first scroll read, pointer to zero
        logic sc_step;    // one scroll copy / clear
        logic draw_rd;    // read new cursor cell
        logic draw_wr;    // draw cursor, load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ptr_last;
        logic is_read;
        logic edit_scroll;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/tmcw_ctrl.sv
// Sequencer for the console writer: reset sweep, read, put and scroll steps.
// Depends on tmcw_pkg; drives the datapath strobes and the input stall.
`default_nettype none

module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_sts,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_READ_OUT,
        S_EDIT,
        S_SC_PRIME,
        S_SCROLL,
        S_DRAW_RD,
        S_DRAW_WR
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.ptr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.is_read ? S_READ_OUT : S_EDIT;
            end
            S_READ_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_read = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EDIT: begin
                o_cmd.edit = 1'b1;
                n_state    = i_sts.edit_scroll ? S_SC_PRIME : S_DRAW_RD;
            end
            S_SC_PRIME: begin
                o_cmd.sc_prime = 1'b1;
                n_state        = S_SCROLL;
            end
            S_SCROLL: begin
                o_cmd.sc_step = 1'b1;
                if (i_sts.ptr_last) n_state = S_DRAW_RD;
            end
            S_DRAW_RD: begin
                o_cmd.draw_rd = 1'b1;
                n_state       = S_DRAW_WR;
            end
            S_DRAW_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.draw_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/tmcw_dpath.sv
// Datapath: cell memory, cursor, attribute registers, sweep pointer, output register.
// Depends on tmcw_pkg; steered by the strobes from tmcw_ctrl.
`default_nettype none

module tmcw_dpath
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_sts,
    input  wire t_in_item             i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ATTR_W-1:0]    i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = $clog2(COLUMNS);
    localparam int RW      = $clog2(ROWS);
    localparam int START_R = (START_ROW < ROWS) ? START_ROW : ROWS - 1;

    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] PTR_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW:0]   SRC_AHEAD = (AW + 1)'(COLUMNS + 1);
    localparam logic [AW:0]   CELLS_X   = (AW + 1)'(CELLS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [AW-1:0]     r_ptr;
    logic [ATTR_W-1:0] r_norm, r_cur_attr;
    logic              r_action;
    logic [7:0]        r_char;
    logic [10:0]       r_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr, cur_addr;
    logic [15:0]   wr_data, edit_data, draw_data;
    logic [AW:0]   src_addr;
    logic          idx_ok;
    logic          is_nul, is_bs, is_nl, wrap_row;

    assign cur_addr = AW'(r_row) * COLS_A + AW'(r_col);
    assign src_addr = (AW + 1)'(r_ptr) + SRC_AHEAD;
    assign idx_ok   = (32'(r_idx) < CELLS);

    assign is_nul = (r_char == CHAR_NUL);
    assign is_bs  = (r_char == CHAR_BS);
    assign is_nl  = (r_char == CHAR_NL);

    // cursor move for a put
    always_comb begin
        n_col    = r_col;
        wrap_row = 1'b0;
        if (is_bs) begin
            if (r_col != '0) n_col = r_col - CW'(1);
        end else if (is_nl) begin
            n_col    = '0;
            wrap_row = 1'b1;
        end else if (!is_nul) begin
            if (r_col == COL_LAST) begin
                n_col    = '0;
                wrap_row = 1'b1;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        // past the last row the cursor stays there and the store scrolls
        n_row = (wrap_row && (r_row != ROW_LAST)) ? r_row + RW'(1) : r_row;
    end

    // old cursor cell: attribute restored, ordinary byte written in
    assign edit_data = (is_nul || is_bs || is_nl) ? {r_norm, r_rd[7:0]} : {r_norm, r_char};
    assign draw_data = {r_cur_attr, (is_bs ? 8'h00 : r_rd[7:0])};

    // memory port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cur_addr;
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = edit_data;
        if (i_cmd.look) begin
            rd_en   = 1'b1;
            rd_addr = r_action ? AW'(r_idx) : cur_addr;
        end
        if (i_cmd.draw_rd) rd_en = 1'b1;
        if (i_cmd.sc_prime) begin
            rd_en   = 1'b1;
            rd_addr = COLS_A;
        end
        if (i_cmd.sc_step) begin
            rd_en   = (src_addr < CELLS_X);
            rd_addr = src_addr[AW-1:0];
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = (r_ptr < COPY_END) ? r_rd : {r_norm, 8'h00};
        end
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = CELL_BLANK;
        end
        if (i_cmd.edit) wr_en = 1'b1;
        if (i_cmd.draw_wr) begin
            wr_en   = 1'b1;
            wr_data = draw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // item latch and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_in.action;
            r_char   <= i_in.char_code;
            r_idx    <= i_in.cell_index;
        end
        if (i_cmd.load_read) begin
            r_out.cell_value    <= idx_ok ? r_rd : 16'h0000;
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_row    <= 5'(r_row);
        end
        if (i_cmd.draw_wr) begin
            r_out.cell_value    <= draw_data;
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_row    <= 5'(r_row);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= RW'(START_R);
            r_ptr       <= '0;
            r_norm      <= NORMAL_ATTR_RST;
            r_cur_attr  <= CURSOR_ATTR_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.edit) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.sc_prime) begin
                r_ptr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.sc_step) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + AW'(1);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NORMAL_ATTR) r_norm <= i_cfg_data;
                if (i_cfg_index == CFG_CURSOR_ATTR) r_cur_attr <= i_cfg_data;
            end
            if (i_cmd.load_read || i_cmd.draw_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.ptr_last    = (r_ptr == PTR_LAST);
    assign o_sts.is_read     = (r_action == ACT_READ);
    assign o_sts.edit_scroll = wrap_row && (r_row == ROW_LAST);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### rtl/text_mode_console_writer.sv
// Top level of the text-mode console writer (COLUMNS x ROWS character cells).
// Depends on tmcw_pkg, tmcw_ctrl and tmcw_dpath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_in (t_in_item)  | into block
//  out     | o_out_valid, i_out_stall, o_out (t_out_item) | out of block
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data          | into block
//
// One item at a time. A read item steps through accept, lookup and load; a put
// item through accept, lookup, edit, cursor read and cursor draw, the last step
// loading the output register. The steps are set by the one write and the one
// registered read port of the cell memory. A put that runs off the last row
// adds a scroll: a priming read, then one cell copied or cleared per cycle over
// the whole store. After reset a clearing pass blanks every cell of the store;
// no item is accepted during it, configuration writes are.
// The output register holds a finished result while o_out is stalled, and the
// next item is already accepted; it only waits at its last step.
`default_nettype none

module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input item channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ATTR_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    tmcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tmcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // an accepted item keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accept");

    // a result is loaded only when the output register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_read || cmd.draw_wr) |-> sts.out_free)
        else $error("output register overwritten");

    // at most one source drives the memory write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_wr, cmd.edit, cmd.sc_step, cmd.draw_wr}))
        else $error("write port conflict");

    // the reported cursor column stays on the screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.cursor_column) < COLUMNS))
        else $error("cursor column out of range");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for text_mode_console_writer: directed table, then random
// put/read items against a shadow copy of the cell store. Uses tmcw_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    // Longest correct quiet stretch is a scroll of the whole store behind a long
    // receiver hold-off; the post-reset clearing pass is about as long.
    localparam int STUCK_LIMIT = 10000;
    localparam int HOLD_OFF    = 300;
    localparam bit BY_HAND     = 1'b1;
    localparam bit BY_MODEL    = 1'b0;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NORMAL_ATTR;
    logic [ATTR_W-1:0]    cfg_data  = '0;
    wire                  o_in_stall;
    wire                  o_out_valid;
    t_out_item            o_out;

    always #2 clk = ~clk;

    text_mode_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out      (o_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow console: cell store, cursor and the two attribute registers.
    // ------------------------------------------------------------------
    logic [15:0] screen [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  attr_norm;
    logic [7:0]  attr_cur;

    t_out_item   reports_due [$];   // cell/cursor reports still owed by the block
    int          mismatches    = 0;
    int          reports_seen  = 0;
    bit          quiet         = 1'b0;  // no idling on either side when set

    initial begin
        for (int i = 0; i < CELLS; i++) screen[i] = CELL_BLANK;
        cur_col   = 0;
        cur_row   = (START_ROW < ROWS) ? START_ROW : ROWS - 1;
        attr_norm = NORMAL_ATTR_RST;
        attr_cur  = CURSOR_ATTR_RST;
    end

    function automatic int unsigned cursor_cell();
        int unsigned pos;
        pos = cur_row * COLS + cur_col;
        return (pos < CELLS) ? pos : 0;
    endfunction

    function automatic void paint_cursor_cell(input logic [7:0] attr);
        int unsigned pos;
        pos = cursor_cell();
        screen[pos] = {attr, screen[pos][7:0]};
    endfunction

    // One console step: read a cell, or put a character and redraw the cursor.
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item   res;
        int unsigned pos;
        res = '0;
        if (it.action == ACT_READ) begin
            res.cell_value = (it.cell_index < CELLS) ? screen[it.cell_index] : 16'h0000;
        end else begin
            paint_cursor_cell(attr_norm);
            if (it.char_code == CHAR_BS) begin
                // backspace never goes past column 0, and always blanks the cell
                if (cur_col > 0) cur_col--;
                screen[cursor_cell()] = {attr_norm, CHAR_NUL};
            end else if (it.char_code != CHAR_NUL) begin
                if (it.char_code == CHAR_NL) begin
                    cur_row++;
                    cur_col = 0;
                end else begin
                    pos = cursor_cell();
                    screen[pos] = {screen[pos][15:8], it.char_code};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_row++;
                    cur_col = 0;
                end
                if (cur_row >= ROWS) begin
                    // scroll up one row, bottom row cleared to the normal attribute
                    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr_norm, CHAR_NUL};
                    cur_row = ROWS - 1;
                end
            end
            paint_cursor_cell(attr_cur);
            res.cell_value = screen[cursor_cell()];
        end
        res.cursor_column = cur_col[6:0];
        res.cursor_row    = cur_row[4:0];
        return res;
    endfunction

    // Mostly puts of random bytes; a few newlines (each at the bottom costs a scroll),
    // backspaces, nulls, and reads spread over the store, near the cursor and
    // past its end.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.action     = ACT_PUT;
        it.char_code  = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 2047));
        pick          = $urandom_range(0, 99);
        if (pick < 22) begin
            it.action = ACT_READ;
            if (pick < 4)
                it.cell_index = 11'($urandom_range(CELLS, 2047));
            else if (pick < 10)
                it.cell_index = 11'(cur_row * COLS + ((cur_col > 0) ? cur_col - 1 : 0));
            else
                it.cell_index = 11'($urandom_range(0, CELLS - 1));
        end else if (pick < 25) begin
            it.char_code = CHAR_NL;
        end else if (pick < 33) begin
            it.char_code = CHAR_BS;
        end else if (pick < 36) begin
            it.char_code = CHAR_NUL;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input side: gap, offer, hold until accepted, then predict.
    // ------------------------------------------------------------------
    task automatic offer(input t_in_item it, input bit by_hand, input t_out_item hand_res);
        int        gap;
        t_out_item res;
        gap = quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        res = console_step(it);
        reports_due.push_back(by_hand ? hand_res : res);
    endtask

    // Stop offering and let every owed report come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (reports_due.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // Attribute registers are only touched with the block idle.
    task automatic set_attrs(input logic [7:0] norm, input logic [7:0] cur);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NORMAL_ATTR;
        cfg_data  <= norm;
        @(negedge clk);
        cfg_index <= CFG_CURSOR_ATTR;
        cfg_data  <= cur;
        @(negedge clk);
        cfg_we    <= 1'b0;
        attr_norm = norm;
        attr_cur  = cur;
    endtask

    task automatic random_items(input int count);
        for (int k = 0; k < count; k++) offer(random_item(), BY_MODEL, '0);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall per item, one long hold-off, field checks.
    // ------------------------------------------------------------------
    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (reports_due.size() == 0) begin
            $error("unexpected report: cell_value %h column %0d row %0d",
                   got.cell_value, got.cursor_column, got.cursor_row);
            mismatches++;
        end else begin
            want = reports_due.pop_front();
            if (got.cell_value !== want.cell_value) begin
                $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
                mismatches++;
            end
            if (got.cursor_column !== want.cursor_column) begin
                $error("cursor_column: expected %0d, got %0d",
                       want.cursor_column, got.cursor_column);
                mismatches++;
            end
            if (got.cursor_row !== want.cursor_row) begin
                $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                mismatches++;
            end
        end
    endtask

    initial begin : take_reports
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            hold = quiet ? 0 : $urandom_range(0, 10);
            // one long hold-off: output register fills, then the input stalls
            if (reports_seen == 100) hold = HOLD_OFF;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (o_out_valid !== 1'b1);
            check_report(o_out);
            reports_seen++;
        end
    end

    // Watchdog: too long without any item moving on either channel.
    int stuck_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Hand-typed reports only where obvious: reset contents,
    // out-of-range reads, read-backs, first cursor draws, BS at column 0.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        action;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic        by_hand;
        logic [15:0] cell_word;
        logic [6:0]  col;
        logic [4:0]  row;
    } t_dir_row;

    localparam int DIR_N = 27;
    t_dir_row dir_tab [DIR_N] = '{
        '{ACT_READ, CHAR_NUL, 11'd0,    BY_HAND,  CELL_BLANK, 7'd0, 5'd14},
        '{ACT_READ, CHAR_NUL, 11'd1999, BY_HAND,  CELL_BLANK, 7'd0, 5'd14},
        '{ACT_READ, CHAR_NUL, 11'd2000, BY_HAND,  16'h0000,   7'd0, 5'd14},  // past the store
        '{ACT_READ, 8'hFF,    11'd2047, BY_HAND,  16'h0000,   7'd0, 5'd14},
        '{ACT_PUT,  CHAR_NUL, 11'd0,    BY_HAND,  16'h7000,   7'd0, 5'd14},  // null: redraw only
        '{ACT_PUT,  8'h41,    11'd0,    BY_HAND,  16'h7000,   7'd1, 5'd14},
        '{ACT_READ, CHAR_NUL, 11'd1120, BY_HAND,  16'h0741,   7'd1, 5'd14},
        '{ACT_PUT,  CHAR_BS,  11'd0,    BY_HAND,  16'h7000,   7'd0, 5'd14},
        '{ACT_PUT,  CHAR_BS,  11'd0,    BY_HAND,  16'h7000,   7'd0, 5'd14},  // stays at col 0
        '{ACT_PUT,  8'hFF,    11'd2047, BY_HAND,  16'h7000,   7'd1, 5'd14},
        '{ACT_PUT,  8'h01,    11'd0,    BY_HAND,  16'h7000,   7'd2, 5'd14},
        '{ACT_PUT,  8'h7F,    11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  8'h80,    11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_READ, CHAR_NUL, 11'd1121, BY_HAND,  16'h0701,   7'd4, 5'd14},
        // ten newlines reach the last row, the eleventh scrolls
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_PUT,  CHAR_NL,  11'd0,    BY_MODEL, 16'h0000,   7'd0, 5'd0},
        '{ACT_READ, CHAR_NUL, 11'd1999, BY_HAND,  CELL_BLANK, 7'd0, 5'd24},  // cleared row
        '{ACT_READ, CHAR_NUL, 11'd1040, BY_MODEL, 16'h0000,   7'd0, 5'd0}    // moved up a row
    };

    initial begin : stimulus
        t_in_item  stim;
        t_out_item hand_res;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            stim.action            = dir_tab[r].action;
            stim.char_code         = dir_tab[r].ch;
            stim.cell_index        = dir_tab[r].idx;
            hand_res.cell_value    = dir_tab[r].cell_word;
            hand_res.cursor_column = dir_tab[r].col;
            hand_res.cursor_row    = dir_tab[r].row;
            offer(stim, dir_tab[r].by_hand, hand_res);
        end

        // Random phases, each under its own attribute pair.
        set_attrs(8'h00, 8'hFF);
        random_items(190);

        set_attrs(8'hFF, 8'h00);
        quiet = 1'b1;           // back-to-back on both sides
        random_items(190);
        quiet = 1'b0;

        set_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_items(190);

        set_attrs(8'h5A, 8'hA5);
        random_items(180);

        drain();
        repeat (40) @(posedge clk);   // catch stray reports
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tmcw_pkg.sv
rtl/tmcw_ctrl.sv
rtl/tmcw_dpath.sv
rtl/text_mode_console_writer.sv
bench/tb.sv
